[src/lzx_match_token_decoder_macros.svh]
// Assertion macros shared by the checker of the token decoder.
`ifndef LZX_MATCH_TOKEN_DECODER_MACROS_SVH
`define LZX_MATCH_TOKEN_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZXD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZXD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/lzxd_pkg.sv]
package lzxd_pkg;

	localparam int POS_W  = 22;
	localparam int OFS_W  = 32;
	localparam int LEN_W  = 9;
	localparam int SLOT_W = 7;
	localparam int BASE_W = 21;
	localparam int VB_W   = 17;

	typedef enum logic [1:0] {
		CMD_START_STREAM = 2'd0,
		CMD_START_BLOCK  = 2'd1,
		CMD_LOAD_OFFSETS = 2'd2,
		CMD_SYMBOL       = 2'd3
	} cmd_t;

	localparam logic [1:0] BK_VERBATIM = 2'd0;
	localparam logic [1:0] BK_ALIGNED  = 2'd1;
	localparam logic [1:0] BK_UNCOMP   = 2'd2;
	localparam logic [1:0] BK_RESERVED = 2'd3;

	localparam logic [1:0] TK_NONE    = 2'd0;
	localparam logic [1:0] TK_LITERAL = 2'd1;
	localparam logic [1:0] TK_MATCH   = 2'd2;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_ZERO_OFS = 3'd1;
	localparam logic [2:0] ERR_BIG_BLK  = 3'd2;
	localparam logic [2:0] ERR_OVERRUN  = 3'd3;
	localparam logic [2:0] ERR_WINDOW   = 3'd4;

	localparam logic REG_WIN_LOG2    = 1'b0;
	localparam logic REG_OUTPUT_SIZE = 1'b1;

	localparam logic [4:0]       WORDER_RESET  = 5'd15;
	localparam logic [POS_W-1:0] OUTSIZE_RESET = 22'd32768;

	typedef struct packed {
		logic [OFS_W-1:0] r0;
		logic [OFS_W-1:0] r1;
		logic [OFS_W-1:0] r2;
		logic [POS_W-1:0] wpos;
		logic [POS_W-1:0] bend;
		logic [1:0]       bkind;
	} state_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [1:0]       block_kind;
		logic [23:0]      blk_len;
		logic [OFS_W-1:0] offset_first;
		logic [OFS_W-1:0] offset_second;
		logic [OFS_W-1:0] offset_third;
		logic [9:0]       main_code;
		logic [7:0]       length_symbol;
		logic [VB_W-1:0]  raw_bits;
		logic [2:0]       aligned_symbol;
	} item_t;

	typedef struct packed {
		logic [1:0]       token_kind;
		logic [7:0]       literal_byte;
		logic [LEN_W-1:0] match_length;
		logic [POS_W-1:0] match_dist;
		logic [POS_W-1:0] out_position;
		logic             block_done;
		logic [2:0]       error_code;
	} result_t;

	// Position base of each slot.
	function automatic logic [BASE_W-1:0] slot_base(input logic [5:0] slot);
		logic [BASE_W-1:0] b;
		unique case (slot)
			6'd0:  b = 21'd0;       6'd1:  b = 21'd1;       6'd2:  b = 21'd2;
			6'd3:  b = 21'd3;       6'd4:  b = 21'd4;       6'd5:  b = 21'd6;
			6'd6:  b = 21'd8;       6'd7:  b = 21'd12;      6'd8:  b = 21'd16;
			6'd9:  b = 21'd24;      6'd10: b = 21'd32;      6'd11: b = 21'd48;
			6'd12: b = 21'd64;      6'd13: b = 21'd96;      6'd14: b = 21'd128;
			6'd15: b = 21'd192;     6'd16: b = 21'd256;     6'd17: b = 21'd384;
			6'd18: b = 21'd512;     6'd19: b = 21'd768;     6'd20: b = 21'd1024;
			6'd21: b = 21'd1536;    6'd22: b = 21'd2048;    6'd23: b = 21'd3072;
			6'd24: b = 21'd4096;    6'd25: b = 21'd6144;    6'd26: b = 21'd8192;
			6'd27: b = 21'd12288;   6'd28: b = 21'd16384;   6'd29: b = 21'd24576;
			6'd30: b = 21'd32768;   6'd31: b = 21'd49152;   6'd32: b = 21'd65536;
			6'd33: b = 21'd98304;   6'd34: b = 21'd131072;  6'd35: b = 21'd196608;
			6'd36: b = 21'd262144;  6'd37: b = 21'd393216;  6'd38: b = 21'd524288;
			6'd39: b = 21'd655360;  6'd40: b = 21'd786432;  6'd41: b = 21'd917504;
			6'd42: b = 21'd1048576; 6'd43: b = 21'd1179648; 6'd44: b = 21'd1310720;
			6'd45: b = 21'd1441792; 6'd46: b = 21'd1572864; 6'd47: b = 21'd1703936;
			6'd48: b = 21'd1835008; 6'd49: b = 21'd1966080;
			default: b = '0;
		endcase
		return b;
	endfunction

	// Number of position slots for a window order, with out-of-range orders clamped.
	function automatic logic [SLOT_W-1:0] slot_limit(input logic [4:0] order);
		logic [SLOT_W-1:0] n;
		unique case (order)
			5'd16: n = 7'd32;
			5'd17: n = 7'd34;
			5'd18: n = 7'd36;
			5'd19: n = 7'd38;
			5'd20: n = 7'd42;
			default: n = (order > 5'd20) ? 7'd50 : 7'd30;
		endcase
		return n;
	endfunction

	function automatic logic [4:0] extra_bits(input logic [5:0] slot);
		logic [5:0] e;
		e = (slot - 6'd2) >> 1;
		if (slot < 6'd4) begin
			return 5'd0;
		end
		return (e > 6'd17) ? 5'd17 : e[4:0];
	endfunction

endpackage

[src/lzxd_token_unit.sv]
module lzxd_token_unit (
	input  lzxd_pkg::item_t      item,
	input  lzxd_pkg::state_t     st,
	input  logic [4:0]           win_log2,
	input  logic [21:0]          output_size,
	output lzxd_pkg::state_t     st_next,
	output lzxd_pkg::result_t    res
);
	import lzxd_pkg::*;

	logic [POS_W-1:0]  room;
	logic              blk_too_big;
	logic [1:0]        bk_eff;
	logic [POS_W-1:0]  bend_new;
	logic              has_room;
	logic [POS_W-1:0]  remaining;
	logic [9:0]        msym;
	logic [2:0]        hdr;
	logic [SLOT_W-1:0] slot;
	logic [LEN_W-1:0]  len;
	logic              slot_bad;
	logic [4:0]        nb;
	logic              use_aligned;
	logic [VB_W:0]     mask_full;
	logic [VB_W:0]     mask_al;
	logic [VB_W-1:0]   vb_part;
	logic [POS_W-1:0]  new_off;
	logic [OFS_W-1:0]  off;
	logic              ofs_zero;

	always_comb begin
		room        = (output_size > st.wpos) ? output_size - st.wpos : '0;
		blk_too_big = item.blk_len > {2'b00, room};
		bk_eff      = (item.block_kind == BK_RESERVED) ? BK_VERBATIM : item.block_kind;
		bend_new    = st.wpos + item.blk_len[POS_W-1:0];
		has_room    = st.bend > st.wpos;
		remaining   = has_room ? st.bend - st.wpos : '0;

		msym = item.main_code - 10'd256;
		hdr  = msym[2:0];
		slot = msym[9:3];
		len  = LEN_W'(hdr) + 9'd2 + ((hdr == 3'd7) ? {1'b0, item.length_symbol} : 9'd0);
		slot_bad = slot >= slot_limit(win_log2);

		// In aligned blocks with at least three extra bits, the low three offset bits come from the aligned symbol.
		nb          = extra_bits(slot[5:0]);
		use_aligned = (st.bkind == BK_ALIGNED) && (nb >= 5'd3);
		mask_full   = ((VB_W+1)'(1) << nb) - (VB_W+1)'(1);
		mask_al     = ((VB_W+1)'(1) << (nb - 5'd3)) - (VB_W+1)'(1);
		if (use_aligned) begin
			vb_part = (item.raw_bits & mask_al[VB_W-1:0]) << 3;
		end else begin
			vb_part = item.raw_bits & mask_full[VB_W-1:0];
		end
		new_off = POS_W'(slot_base(slot[5:0])) + POS_W'(vb_part)
			+ (use_aligned ? POS_W'(item.aligned_symbol) : '0) - POS_W'(2);
	end

	always_comb begin
		st_next  = st;
		off      = '0;
		ofs_zero = 1'b0;
		res.token_kind   = TK_NONE;
		res.literal_byte = '0;
		res.match_length = '0;
		res.match_dist   = '0;
		res.out_position = st.wpos;
		res.error_code   = ERR_OK;

		unique case (cmd_t'(item.command))
			CMD_START_STREAM: begin
				st_next.r0    = OFS_W'(1);
				st_next.r1    = OFS_W'(1);
				st_next.r2    = OFS_W'(1);
				st_next.wpos  = '0;
				st_next.bend  = '0;
				st_next.bkind = BK_VERBATIM;
				res.out_position = '0;
			end
			CMD_START_BLOCK: begin
				if (blk_too_big) begin
					res.error_code = ERR_BIG_BLK;
				end else begin
					st_next.bkind = bk_eff;
					st_next.bend  = bend_new;
					if (bk_eff == BK_UNCOMP) begin
						st_next.wpos = bend_new;
					end
				end
			end
			CMD_LOAD_OFFSETS: begin
				st_next.r0 = item.offset_first;
				st_next.r1 = item.offset_second;
				st_next.r2 = item.offset_third;
				ofs_zero = (item.offset_first == '0) || (item.offset_second == '0)
					|| (item.offset_third == '0);
				if (ofs_zero) begin
					res.error_code = ERR_ZERO_OFS;
				end
			end
			CMD_SYMBOL: begin
				if (!has_room) begin
					res.error_code = ERR_OVERRUN;
				end else if (!item.main_code[9] && !item.main_code[8]) begin
					res.token_kind   = TK_LITERAL;
					res.literal_byte = item.main_code[7:0];
					st_next.wpos     = st.wpos + POS_W'(1);
				end else if (slot_bad) begin
					res.error_code = ERR_WINDOW;
				end else begin
					// Reuse swaps the chosen recent offset to the front; a new one shifts in.
					case (slot)
						7'd0: begin
							off = st.r0;
						end
						7'd1: begin
							off = st.r1;
							st_next.r1 = st.r0;
							st_next.r0 = st.r1;
						end
						7'd2: begin
							off = st.r2;
							st_next.r2 = st.r0;
							st_next.r0 = st.r2;
						end
						default: begin
							off = OFS_W'(new_off);
							st_next.r2 = st.r1;
							st_next.r1 = st.r0;
							st_next.r0 = OFS_W'(new_off);
						end
					endcase
					if (POS_W'(len) > remaining) begin
						res.error_code = ERR_OVERRUN;
					end else if (off == '0) begin
						res.error_code = ERR_ZERO_OFS;
					end else if (off > OFS_W'(st.wpos)) begin
						res.error_code = ERR_WINDOW;
					end else begin
						res.token_kind   = TK_MATCH;
						res.match_length = len;
						res.match_dist   = off[POS_W-1:0];
						st_next.wpos     = st.wpos + POS_W'(len);
					end
				end
			end
			default: begin
				st_next = st;
			end
		endcase

		res.block_done = st_next.wpos >= st_next.bend;
	end

endmodule

[src/lzx_match_token_decoder.sv]
// LZX match token decoder.
// Input channel (in_valid / in_stall) carries one request per decoded main-code
// symbol or per control command: start stream, start block, or load of the
// three recent offsets. Each accepted request yields exactly one result on the
// output channel (out_valid / out_stall): a literal, a match with its length
// and backward distance, or an acknowledge, plus the start position, the
// block-done flag and an error code.
// Two register stages: a request accepted into the input register is decoded
// against the recent-offset and position state into the result register.
// Throughput is one request per cycle while the receiver does not stall; the
// state update is a single pass of selection and a 22-bit add and compare
// between the two registers.
// When the receiver stalls, the result register holds, one more request may
// wait in the input register, and then in_stall rises.
// Reset clears both registers and sets recent offsets to 1, positions to zero,
// block kind to verbatim, the window order to 15 and output_size to 32768.
// Configuration is written through wr_en / wr_index / wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
module lzx_match_token_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [21:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [1:0]  block_kind,
	input  logic [23:0] blk_len,
	input  logic [31:0] offset_first,
	input  logic [31:0] offset_second,
	input  logic [31:0] offset_third,
	input  logic [9:0]  main_code,
	input  logic [7:0]  length_symbol,
	input  logic [16:0] raw_bits,
	input  logic [2:0]  aligned_symbol,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  token_kind,
	output logic [7:0]  literal_byte,
	output logic [8:0]  match_length,
	output logic [21:0] match_dist,
	output logic [21:0] out_position,
	output logic        block_done,
	output logic [2:0]  error_code
);
	import lzxd_pkg::*;

	logic [4:0]       win_log2_q;
	logic [POS_W-1:0] output_size_q;
	state_t           st_q;
	state_t           st_next;
	item_t            item_s1;
	logic             valid_s1;
	result_t          res;
	result_t          res_s2;
	logic             valid_s2;
	logic             adv;
	logic             in_take;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	lzxd_token_unit u_unit (
		.item         (item_s1),
		.st           (st_q),
		.win_log2     (win_log2_q),
		.output_size  (output_size_q),
		.st_next      (st_next),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_log2_q    <= WORDER_RESET;
			output_size_q <= OUTSIZE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIN_LOG2:    win_log2_q    <= wr_data[4:0];
				REG_OUTPUT_SIZE: output_size_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.command        <= command;
			item_s1.block_kind     <= block_kind;
			item_s1.blk_len        <= blk_len;
			item_s1.offset_first   <= offset_first;
			item_s1.offset_second  <= offset_second;
			item_s1.offset_third   <= offset_third;
			item_s1.main_code      <= main_code;
			item_s1.length_symbol  <= length_symbol;
			item_s1.raw_bits       <= raw_bits;
			item_s1.aligned_symbol <= aligned_symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			st_q.r0     <= OFS_W'(1);
			st_q.r1     <= OFS_W'(1);
			st_q.r2     <= OFS_W'(1);
			st_q.wpos   <= '0;
			st_q.bend   <= '0;
			st_q.bkind  <= BK_VERBATIM;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign token_kind   = res_s2.token_kind;
	assign literal_byte = res_s2.literal_byte;
	assign match_length = res_s2.match_length;
	assign match_dist   = res_s2.match_dist;
	assign out_position = res_s2.out_position;
	assign block_done   = res_s2.block_done;
	assign error_code   = res_s2.error_code;

endmodule

[src/lzxd_checker.sv]
`include "lzx_match_token_decoder_macros.svh"

module lzxd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  token_kind,
	input logic [8:0]  match_length,
	input logic [21:0] match_dist,
	input logic [21:0] out_position,
	input logic [2:0]  error_code
);
	import lzxd_pkg::*;

	logic        held_full;
	logic        err_out;
	logic        no_token;
	logic        match_out;
	logic        match_sane;
	logic [26:0] held_view;

	assign held_full  = out_valid && out_stall;
	assign err_out    = out_valid && (error_code != ERR_OK);
	assign no_token   = (token_kind == TK_NONE) && (match_length == '0) && (match_dist == '0);
	assign match_out  = out_valid && (token_kind == TK_MATCH);
	assign match_sane = (match_dist != '0) && (match_dist <= out_position)
		&& (match_length >= 9'd2);
	assign held_view  = {token_kind, error_code, out_position};

	// The input side may only back up when a finished result is being held.
	`LZXD_ASSERT_NOW(a_stall_only_when_full, in_stall, held_full, "in_stall without held result")

	// A failed request carries no token.
	`LZXD_ASSERT_NOW(a_error_no_token, err_out, no_token, "error result carries a token")

	// A match never reaches before the start of output and is at least two bytes long.
	`LZXD_ASSERT_NOW(a_match_in_window, match_out, match_sane, "match out of range")

	// A held result stays put while the receiver stalls.
	`LZXD_ASSERT_NEXT(a_result_held, held_full, out_valid && $stable(held_view), "stalled result changed")

endmodule

bind lzx_match_token_decoder lzxd_checker u_lzxd_checker (.*);
